// ===== src/cpfa_pkg.sv =====
package cpfa_pkg;

	// attitude sample, one per input transaction
	typedef struct packed {
		logic signed [31:0] cam_pitch;
		logic signed [31:0] cam_heading;
		logic signed [31:0] latitude;
		logic signed [31:0] longitude;
		logic signed [31:0] altitude_ft;
		logic signed [31:0] body_pitch;
		logic signed [31:0] body_roll;
		logic signed [31:0] body_heading;
	} att_t;

	// one word of the pose record, one per output transaction
	typedef struct packed {
		logic [4:0]         word_index;
		logic signed [63:0] word_value;
		logic               last_word;
	} pose_t;

	// angle constants in Q.30, wide enough for the range reduction
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [4:0]         CORDIC_LAST = 5'd30;

	localparam logic signed [63:0] POSE_MARKER = 64'h3D751E25074AB1C8;
	localparam logic signed [63:0] SIXTY_Q32   = 64'h0000003C_00000000;
	localparam logic [13:0]        COUNT_WRAP  = 14'd9999;
	localparam logic [4:0]         LAST_WORD   = 5'd16;
	localparam logic [5:0]         LAST_OP     = 6'd55;
	localparam logic [2:0]         LAST_ANGLE  = 3'd5;

	// scratch memory slots; sine of angle k at 2k, cosine at 2k+1
	localparam int          MEM_DEPTH = 48;
	localparam logic [5:0] M_SP    = 6'd0;
	localparam logic [5:0] M_CP    = 6'd1;
	localparam logic [5:0] M_SH    = 6'd2;
	localparam logic [5:0] M_CH    = 6'd3;
	localparam logic [5:0] M_BSP   = 6'd4;
	localparam logic [5:0] M_BP    = 6'd5;
	localparam logic [5:0] M_BSR   = 6'd6;
	localparam logic [5:0] M_BR    = 6'd7;
	localparam logic [5:0] M_BSY   = 6'd8;
	localparam logic [5:0] M_BY    = 6'd9;
	localparam logic [5:0] M_LC    = 6'd11;
	localparam logic [5:0] M_LAT   = 6'd12;
	localparam logic [5:0] M_LON   = 6'd13;
	localparam logic [5:0] M_ALT   = 6'd14;
	localparam logic [5:0] M_U     = 6'd15;
	localparam logic [5:0] M_V     = 6'd16;
	localparam logic [5:0] M_B     = 6'd17;
	localparam logic [5:0] M_C     = 6'd26;
	localparam logic [5:0] M_T     = 6'd35;
	localparam logic [5:0] M_E     = 6'd44;
	localparam logic [5:0] M_EAST  = 6'd45;
	localparam logic [5:0] M_NORTH = 6'd46;
	localparam logic [5:0] M_DOWN  = 6'd47;

	// operand a modes
	localparam logic [1:0] AM_FULL = 2'd0;
	localparam logic [1:0] AM_HI   = 2'd1;
	localparam logic [1:0] AM_LO   = 2'd2;

	// operand b sources
	localparam logic [2:0] BS_MEM   = 3'd0;
	localparam logic [2:0] BS_ONE   = 3'd1;
	localparam logic [2:0] BS_ZERO  = 3'd2;
	localparam logic [2:0] BS_EARTH = 3'd3;
	localparam logic [2:0] BS_FTM   = 3'd4;

	// product scaling
	localparam logic [2:0] SH_R30   = 3'd0;
	localparam logic [2:0] SH_R26   = 3'd1;
	localparam logic [2:0] SH_R8    = 3'd2;
	localparam logic [2:0] SH_NONE  = 3'd3;
	localparam logic [2:0] SH_L4    = 3'd4;
	localparam logic [2:0] SH_L16   = 3'd5;

	// accumulator modes
	localparam logic [1:0] AC_LD  = 2'd0;
	localparam logic [1:0] AC_ADD = 2'd1;
	localparam logic [1:0] AC_SUB = 2'd2;
	localparam logic [1:0] AC_NEG = 2'd3;

	typedef struct packed {
		logic [5:0] a_addr;
		logic [1:0] a_mode;
		logic [2:0] b_src;
		logic [5:0] b_addr;
		logic [2:0] shift;
		logic [1:0] acc;
		logic       wr;
		logic [5:0] dst;
	} op_t;

	function automatic op_t mk_op(input logic [5:0] a, input logic [1:0] am,
		input logic [2:0] bs, input logic [5:0] b, input logic [2:0] sh,
		input logic [1:0] ac, input logic wr, input logic [5:0] dst);
		op_t o;
		o.a_addr = a;
		o.a_mode = am;
		o.b_src  = bs;
		o.b_addr = b;
		o.shift  = sh;
		o.acc    = ac;
		o.wr     = wr;
		o.dst    = dst;
		return o;
	endfunction

	// multiply program: body matrix, camera matrix, product, position
	function automatic op_t op_rom(input logic [5:0] idx);
		op_t o;
		o = mk_op(M_SP, AM_FULL, BS_ZERO, M_SP, SH_R30, AC_LD, 1'b0, M_U);
		case (idx)
			6'd0:  o = mk_op(M_BY, AM_FULL, BS_MEM, M_BP, SH_R30, AC_LD, 1'b1, M_B);
			6'd1:  o = mk_op(M_BY, AM_FULL, BS_MEM, M_BSP, SH_R30, AC_LD, 1'b1, M_U);
			6'd2:  o = mk_op(M_BSY, AM_FULL, BS_MEM, M_BSP, SH_R30, AC_LD, 1'b1, M_V);
			6'd3:  o = mk_op(M_U, AM_FULL, BS_MEM, M_BSR, SH_R30, AC_LD, 1'b0, M_U);
			6'd4:  o = mk_op(M_BSY, AM_FULL, BS_MEM, M_BR, SH_R30, AC_SUB, 1'b1, M_B + 6'd1);
			6'd5:  o = mk_op(M_U, AM_FULL, BS_MEM, M_BR, SH_R30, AC_LD, 1'b0, M_U);
			6'd6:  o = mk_op(M_BSY, AM_FULL, BS_MEM, M_BSR, SH_R30, AC_ADD, 1'b1, M_B + 6'd2);
			6'd7:  o = mk_op(M_BSY, AM_FULL, BS_MEM, M_BP, SH_R30, AC_LD, 1'b1, M_B + 6'd3);
			6'd8:  o = mk_op(M_V, AM_FULL, BS_MEM, M_BSR, SH_R30, AC_LD, 1'b0, M_U);
			6'd9:  o = mk_op(M_BY, AM_FULL, BS_MEM, M_BR, SH_R30, AC_ADD, 1'b1, M_B + 6'd4);
			6'd10: o = mk_op(M_V, AM_FULL, BS_MEM, M_BR, SH_R30, AC_LD, 1'b0, M_U);
			6'd11: o = mk_op(M_BY, AM_FULL, BS_MEM, M_BSR, SH_R30, AC_SUB, 1'b1, M_B + 6'd5);
			6'd12: o = mk_op(M_BSP, AM_FULL, BS_ONE, M_BSP, SH_R30, AC_NEG, 1'b1, M_B + 6'd6);
			6'd13: o = mk_op(M_BP, AM_FULL, BS_MEM, M_BSR, SH_R30, AC_LD, 1'b1, M_B + 6'd7);
			6'd14: o = mk_op(M_BP, AM_FULL, BS_MEM, M_BR, SH_R30, AC_LD, 1'b1, M_B + 6'd8);
			6'd15: o = mk_op(M_CH, AM_FULL, BS_MEM, M_CP, SH_R30, AC_LD, 1'b1, M_C);
			6'd16: o = mk_op(M_SH, AM_FULL, BS_ONE, M_SH, SH_R30, AC_NEG, 1'b1, M_C + 6'd1);
			6'd17: o = mk_op(M_CH, AM_FULL, BS_MEM, M_SP, SH_R30, AC_LD, 1'b1, M_C + 6'd2);
			6'd18: o = mk_op(M_SH, AM_FULL, BS_MEM, M_CP, SH_R30, AC_LD, 1'b1, M_C + 6'd3);
			6'd19: o = mk_op(M_CH, AM_FULL, BS_ONE, M_CH, SH_R30, AC_LD, 1'b1, M_C + 6'd4);
			6'd20: o = mk_op(M_SH, AM_FULL, BS_MEM, M_SP, SH_R30, AC_LD, 1'b1, M_C + 6'd5);
			6'd21: o = mk_op(M_SP, AM_FULL, BS_ONE, M_SP, SH_R30, AC_NEG, 1'b1, M_C + 6'd6);
			6'd22: o = mk_op(M_SP, AM_FULL, BS_ZERO, M_SP, SH_R30, AC_LD, 1'b1, M_C + 6'd7);
			6'd23: o = mk_op(M_CP, AM_FULL, BS_ONE, M_CP, SH_R30, AC_LD, 1'b1, M_C + 6'd8);
			6'd51: o = mk_op(M_LON, AM_FULL, BS_MEM, M_LC, SH_R26, AC_LD, 1'b1, M_E);
			6'd52: o = mk_op(M_E, AM_HI, BS_EARTH, M_E, SH_L16, AC_LD, 1'b0, M_E);
			6'd53: o = mk_op(M_E, AM_LO, BS_EARTH, M_E, SH_NONE, AC_ADD, 1'b1, M_EAST);
			6'd54: o = mk_op(M_LAT, AM_FULL, BS_EARTH, M_LAT, SH_L4, AC_LD, 1'b1, M_NORTH);
			6'd55: o = mk_op(M_ALT, AM_FULL, BS_FTM, M_ALT, SH_R8, AC_NEG, 1'b1, M_DOWN);
			default: begin
				// matrix product: three products per entry
				for (int r = 0; r < 3; r++) begin
					for (int k = 0; k < 3; k++) begin
						for (int m = 0; m < 3; m++) begin
							if (idx == 6'(24 + r * 9 + k * 3 + m)) begin
								o = mk_op(6'(M_B + 3 * r + m), AM_FULL, BS_MEM,
									6'(M_C + 3 * m + k), SH_R30,
									(m == 0) ? AC_LD : AC_ADD, (m == 2),
									6'(M_T + 3 * r + k));
							end
						end
					end
				end
			end
		endcase
		return o;
	endfunction

	// arctangent table, Q.30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:  v = 34'sh03243F6A8;
			5'd1:  v = 34'sh01DAC6705;
			5'd2:  v = 34'sh00FADBAFC;
			5'd3:  v = 34'sh007F56EA6;
			5'd4:  v = 34'sh003FEAB76;
			5'd5:  v = 34'sh001FFD55B;
			5'd6:  v = 34'sh000FFFAAA;
			5'd7:  v = 34'sh0007FFF55;
			5'd8:  v = 34'sh0003FFFEA;
			5'd9:  v = 34'sh0001FFFFD;
			5'd10: v = 34'sh0000FFFFF;
			5'd11: v = 34'sh00007FFFF;
			5'd12: v = 34'sh00003FFFF;
			5'd13: v = 34'sh00001FFFF;
			5'd14: v = 34'sh00000FFFF;
			5'd15: v = 34'sh000007FFF;
			5'd16: v = 34'sh000003FFF;
			5'd17: v = 34'sh000001FFF;
			5'd18: v = 34'sh000000FFF;
			5'd19: v = 34'sh0000007FF;
			5'd20: v = 34'sh0000003FF;
			5'd21: v = 34'sh0000001FF;
			5'd22: v = 34'sh0000000FF;
			5'd23: v = 34'sh00000007F;
			5'd24: v = 34'sh00000003F;
			5'd25: v = 34'sh00000001F;
			5'd26: v = 34'sh00000000F;
			5'd27: v = 34'sh000000008;
			5'd28: v = 34'sh000000004;
			5'd29: v = 34'sh000000002;
			5'd30: v = 34'sh000000001;
			default: v = 34'sh000000000;
		endcase
		return v;
	endfunction

endpackage

// ===== src/cpfa_cordic.sv =====
module cpfa_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [33:0] sin_val,
	output logic signed [33:0] cos_val
);
	import cpfa_pkg::*;

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic               busy_q, neg_q, done_q;
	logic signed [35:0] a0, a1, a2;
	logic               neg_d;
	logic signed [33:0] xs, ys, at;

	// range reduction to [-pi/2, pi/2], cosine sign fold
	always_comb begin
		a0 = 36'(angle) <<< 2;
		a1 = a0;
		if (a0 > PI_Q30) begin
			a1 = a0 - TWO_PI_Q30;
		end else if (a0 < -PI_Q30) begin
			a1 = a0 + TWO_PI_Q30;
		end
		a2 = a1;
		neg_d = 1'b0;
		if (a1 > HALF_PI_Q30) begin
			a2 = PI_Q30 - a1;
			neg_d = 1'b1;
		end else if (a1 < -HALF_PI_Q30) begin
			a2 = -PI_Q30 - a1;
			neg_d = 1'b1;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = atan_q30(i_q);

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == CORDIC_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rotation datapath, one micro-rotation per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= a2[33:0];
			neg_q <= neg_d;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign sin_val = y_q;
	assign cos_val = neg_q ? -x_q : x_q;

endmodule

// ===== src/camera_pose_from_attitude.sv =====
// channel | direction | handshake               | payload
// att     | in        | att_valid / att_ready   | cpfa_pkg::att_t, one attitude sample
// pose    | out       | pose_valid / pose_ready | cpfa_pkg::pose_t, one of 17 record words
//
// one sample loads latitude, longitude and altitude, then makes six sine/cosine runs of the
// 31-step cordic, then 56 multiply slots (read, multiply, write back) on the
// shared 33x33 multiplier, then 17 words, each read and then loaded into pose.
// att_ready is high only while idle; the last word may still wait in the output
// register when the next sample is taken.
// arst_n clears the sequencer, the output valid and the frame counter.
// a stalled pose output holds the sequencer in its emit step.
module camera_pose_from_attitude (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             att_valid,
	output logic             att_ready,
	input  cpfa_pkg::att_t   att,
	output logic             pose_valid,
	input  logic             pose_ready,
	output cpfa_pkg::pose_t  pose
);
	import cpfa_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOAD   = 4'd1;
	localparam logic [3:0] ST_CSTART = 4'd2;
	localparam logic [3:0] ST_CWAIT  = 4'd3;
	localparam logic [3:0] ST_WSIN   = 4'd4;
	localparam logic [3:0] ST_WCOS   = 4'd5;
	localparam logic [3:0] ST_OP_RD  = 4'd6;
	localparam logic [3:0] ST_OP_MUL = 4'd7;
	localparam logic [3:0] ST_OP_WB  = 4'd8;
	localparam logic [3:0] ST_EM_RD  = 4'd9;
	localparam logic [3:0] ST_EM_LD  = 4'd10;

	logic [3:0]  state_q;
	logic [1:0]  ld_q;
	logic [2:0]  ang_q;
	logic [5:0]  op_q;
	logic [4:0]  word_q;
	logic [13:0] count_q;
	att_t        att_q;
	pose_t       pose_q;
	logic        pose_valid_q;

	logic signed [63:0] mem [MEM_DEPTH];
	logic signed [63:0] rda_q, rdb_q;
	logic signed [65:0] prod_q;
	logic signed [63:0] acc_q, s1_q, s2_q;

	logic               accept, slot_free, emit_load;
	logic               cord_done;
	logic signed [31:0] cord_angle;
	logic signed [33:0] cord_sin, cord_cos;
	op_t                op;
	logic               we, re;
	logic [5:0]         waddr, ra, rb;
	logic signed [63:0] wdata;
	logic signed [32:0] a_op, b_op;
	logic signed [65:0] scaled;
	logic signed [63:0] wb_val, acc_d;
	logic signed [63:0] word_val, neg_word;
	logic [5:0]         word_addr;
	logic [13:0]        count_inc;

	assign accept    = att_valid && att_ready;
	assign att_ready = (state_q == ST_IDLE);
	assign op        = op_rom(op_q);
	assign slot_free = !pose_valid_q || pose_ready;
	assign emit_load = (state_q == ST_EM_LD) && slot_free;

	// angle fed to the cordic
	always_comb begin
		case (ang_q)
			3'd0:    cord_angle = att_q.cam_pitch;
			3'd1:    cord_angle = att_q.cam_heading;
			3'd2:    cord_angle = att_q.body_pitch;
			3'd3:    cord_angle = att_q.body_roll;
			3'd4:    cord_angle = att_q.body_heading;
			3'd5:    cord_angle = att_q.latitude;
			default: cord_angle = '0;
		endcase
	end

	cpfa_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_CSTART),
		.angle   (cord_angle),
		.done    (cord_done),
		.sin_val (cord_sin),
		.cos_val (cord_cos)
	);

	// record word to scratch slot
	always_comb begin
		case (word_q)
			5'd2:    word_addr = M_T;
			5'd3:    word_addr = M_T + 6'd3;
			5'd4:    word_addr = M_T + 6'd6;
			5'd5:    word_addr = M_EAST;
			5'd6:    word_addr = M_T + 6'd1;
			5'd7:    word_addr = M_T + 6'd4;
			5'd8:    word_addr = M_T + 6'd7;
			5'd9:    word_addr = M_NORTH;
			5'd10:   word_addr = M_T + 6'd2;
			5'd11:   word_addr = M_T + 6'd5;
			5'd12:   word_addr = M_T + 6'd8;
			5'd13:   word_addr = M_DOWN;
			default: word_addr = M_T;
		endcase
	end

	// multiply operands
	always_comb begin
		case (op.a_mode)
			AM_HI:   a_op = 33'(rda_q >>> 16);
			AM_LO:   a_op = {17'd0, rda_q[15:0]};
			default: a_op = rda_q[32:0];
		endcase
		case (op.b_src)
			BS_ONE:   b_op = 33'sd1073741824;
			BS_ZERO:  b_op = '0;
			BS_EARTH: b_op = 33'sd6378137;
			BS_FTM:   b_op = 33'sd1309106032;
			default:  b_op = rdb_q[32:0];
		endcase
	end

	// product scaling and accumulate
	always_comb begin
		case (op.shift)
			SH_R30:  scaled = (prod_q + 66'sd536870912) >>> 30;
			SH_R26:  scaled = (prod_q + 66'sd33554432) >>> 26;
			SH_R8:   scaled = (prod_q + 66'sd128) >>> 8;
			SH_L4:   scaled = prod_q <<< 4;
			SH_L16:  scaled = prod_q <<< 16;
			default: scaled = prod_q;
		endcase
		wb_val = scaled[63:0];
		case (op.acc)
			AC_ADD:  acc_d = acc_q + wb_val;
			AC_SUB:  acc_d = acc_q - wb_val;
			AC_NEG:  acc_d = -wb_val;
			default: acc_d = wb_val;
		endcase
	end

	// scratch memory port control
	always_comb begin
		we    = 1'b0;
		waddr = M_LAT;
		wdata = acc_d;
		re    = 1'b0;
		ra    = op.a_addr;
		rb    = op.b_addr;
		case (state_q)
			ST_LOAD: begin
				we = 1'b1;
				case (ld_q)
					2'd0: begin
						waddr = M_LAT;
						wdata = 64'(att_q.latitude);
					end
					2'd1: begin
						waddr = M_LON;
						wdata = 64'(att_q.longitude);
					end
					default: begin
						waddr = M_ALT;
						wdata = 64'(att_q.altitude_ft);
					end
				endcase
			end
			ST_WSIN: begin
				we    = 1'b1;
				waddr = {2'b00, ang_q, 1'b0};
				wdata = 64'(cord_sin);
			end
			ST_WCOS: begin
				we    = 1'b1;
				waddr = {2'b00, ang_q, 1'b1};
				wdata = 64'(cord_cos);
			end
			ST_OP_RD: re = 1'b1;
			ST_OP_WB: begin
				we    = op.wr;
				waddr = op.dst;
			end
			ST_EM_RD: begin
				re = 1'b1;
				ra = word_addr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rda_q <= mem[ra];
			rdb_q <= mem[rb];
		end
	end

	// shared multiplier and accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_OP_MUL) begin
			prod_q <= a_op * b_op;
		end
		if (state_q == ST_OP_WB) begin
			acc_q <= acc_d;
		end
	end

	// record word value
	always_comb begin
		case (word_q)
			5'd0:    word_val = POSE_MARKER;
			5'd1:    word_val = {18'd0, count_q, 32'd0};
			5'd5,
			5'd9,
			5'd13:   word_val = rda_q;
			5'd14:   word_val = SIXTY_Q32;
			5'd15:   word_val = s1_q;
			5'd16:   word_val = s2_q;
			default: word_val = rda_q <<< 2;
		endcase
		neg_word = -word_val;
	end

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

	// running sums over words 1 to 14
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (emit_load && (word_q inside {[5'd1:5'd14]})) begin
			s1_q <= sat_add(s1_q, word_val);
			s2_q <= sat_add(s2_q, word_q[0] ? word_val : neg_word);
		end
	end

	assign count_inc = count_q + 14'd1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ld_q    <= '0;
			ang_q   <= '0;
			op_q    <= '0;
			word_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
						ld_q    <= '0;
						count_q <= (count_inc > COUNT_WRAP) ? 14'd1 : count_inc;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 2'd1;
					if (ld_q == 2'd2) begin
						state_q <= ST_CSTART;
						ang_q   <= '0;
					end
				end
				ST_CSTART: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (cord_done) begin
						state_q <= ST_WSIN;
					end
				end
				ST_WSIN: state_q <= ST_WCOS;
				ST_WCOS: begin
					if (ang_q == LAST_ANGLE) begin
						state_q <= ST_OP_RD;
						op_q    <= '0;
					end else begin
						ang_q   <= ang_q + 3'd1;
						state_q <= ST_CSTART;
					end
				end
				ST_OP_RD:  state_q <= ST_OP_MUL;
				ST_OP_MUL: state_q <= ST_OP_WB;
				ST_OP_WB: begin
					if (op_q == LAST_OP) begin
						state_q <= ST_EM_RD;
						word_q  <= '0;
					end else begin
						op_q    <= op_q + 6'd1;
						state_q <= ST_OP_RD;
					end
				end
				ST_EM_RD: state_q <= ST_EM_LD;
				ST_EM_LD: begin
					if (slot_free) begin
						if (word_q == LAST_WORD) begin
							state_q <= ST_IDLE;
						end else begin
							word_q  <= word_q + 5'd1;
							state_q <= ST_EM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (accept) begin
			att_q <= att;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid_q <= 1'b0;
		end else if (emit_load) begin
			pose_valid_q <= 1'b1;
		end else if (pose_ready) begin
			pose_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			pose_q.word_index <= word_q;
			pose_q.word_value <= word_val;
			pose_q.last_word  <= (word_q == LAST_WORD);
		end
	end

	assign pose_valid = pose_valid_q;
	assign pose       = pose_q;

endmodule

// ===== src/cpfa_checker.sv =====
module cpfa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             att_valid,
	input logic             att_ready,
	input logic             pose_valid,
	input logic             pose_ready,
	input cpfa_pkg::pose_t  pose
);
	import cpfa_pkg::*;

	// a stalled word holds
	a_pose_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_ready |=> pose_valid && $stable(pose))
		else $error("pose word changed while stalled");

	// last flag marks exactly the final word
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid |-> (pose.last_word == (pose.word_index == LAST_WORD)))
		else $error("last_word does not match word_index");

	// word index stays within the record
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid |-> pose.word_index <= LAST_WORD)
		else $error("word_index beyond record");

	// busy after a sample transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		att_valid && att_ready |=> !att_ready)
		else $error("ready right after sample transaction");

	// word zero carries the marker
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose.word_index == 5'd0 |-> pose.word_value == POSE_MARKER)
		else $error("word zero is not the marker");

endmodule

bind camera_pose_from_attitude cpfa_checker u_cpfa_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cpfa_pkg::*;

	localparam int  STALL_LIMIT = 6000;
	localparam int  TAIL_CYCLES = 60;
	localparam longint PI_A     = 64'sd3373259426;
	localparam longint TWO_PI_A = 64'sd6746518852;
	localparam longint HALF_PI_A = 64'sd1686629713;
	localparam longint GAIN_A   = 64'sd652032874;
	localparam longint R_EARTH  = 64'sd6378137;
	localparam longint FT_M     = 64'sd1309106032;
	localparam longint MARKER   = 64'h3D751E25074AB1C8;
	localparam longint ONE_Q32  = 64'sd4294967296;
	localparam int     WRAP_AT  = 9999;
	localparam int     REC_LEN  = 17;

	logic   clk;
	logic   arst_n;
	logic   att_valid;
	logic   att_ready;
	att_t   att;
	logic   pose_valid;
	logic   pose_ready;
	pose_t  pose;

	pose_t  pose_words_q[$];
	logic [13:0] frame_num;
	longint arctan_q30[31];
	int     mismatch_cnt;
	int     samples_sent;
	int     words_checked;
	int     quiet_cycles;
	int     hold_off_cycles;
	bit     idle_on;

	camera_pose_from_attitude dut (
		.clk(clk),
		.arst_n(arst_n),
		.att_valid(att_valid),
		.att_ready(att_ready),
		.att(att),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose(pose)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// q.30 product rounded back to q.30
	function automatic longint rmul30(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// saturating 64-bit add
	function automatic longint sat_add64(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return longint'(s);
	endfunction

	// range reduction, then rotation-mode cordic
	task automatic sine_cosine(input logic signed [31:0] ang, output longint s,
		output longint c);
		longint a, x, y, nx;
		bit flip;
		a = ang;
		a = a * 4;
		x = GAIN_A;
		y = 0;
		flip = 1'b0;
		if (a > PI_A)
			a = a - TWO_PI_A;
		else if (a < -PI_A)
			a = a + TWO_PI_A;
		if (a > HALF_PI_A) begin
			a = PI_A - a;
			flip = 1'b1;
		end else if (a < -HALF_PI_A) begin
			a = -PI_A - a;
			flip = 1'b1;
		end
		for (int i = 0; i < 31; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				a = a - arctan_q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				a = a + arctan_q30[i];
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endtask

	// expected 17-word pose record for one attitude sample
	task automatic predict_pose_record(input att_t in);
		longint sp, cp, sh, ch, bsp, bp, bsr, br, bsy, by, ls, lc;
		longint bm[9], cm[9], tm[9], w[REC_LEN], s1, s2, lat, lon, alt;
		pose_t p;
		sine_cosine(in.cam_pitch, sp, cp);
		sine_cosine(in.cam_heading, sh, ch);
		sine_cosine(in.body_pitch, bsp, bp);
		sine_cosine(in.body_roll, bsr, br);
		sine_cosine(in.body_heading, bsy, by);
		sine_cosine(in.latitude, ls, lc);
		lat = in.latitude;
		lon = in.longitude;
		alt = in.altitude_ft;

		// body rotation, yaw-pitch-roll
		bm[0] = rmul30(by, bp);
		bm[1] = rmul30(rmul30(by, bsp), bsr) - rmul30(bsy, br);
		bm[2] = rmul30(rmul30(by, bsp), br) + rmul30(bsy, bsr);
		bm[3] = rmul30(bsy, bp);
		bm[4] = rmul30(rmul30(bsy, bsp), bsr) + rmul30(by, br);
		bm[5] = rmul30(rmul30(bsy, bsp), br) - rmul30(by, bsr);
		bm[6] = -bsp;
		bm[7] = rmul30(bp, bsr);
		bm[8] = rmul30(bp, br);

		// camera rotation, yaw-pitch
		cm[0] = rmul30(ch, cp);
		cm[1] = -sh;
		cm[2] = rmul30(ch, sp);
		cm[3] = rmul30(sh, cp);
		cm[4] = ch;
		cm[5] = rmul30(sh, sp);
		cm[6] = -sp;
		cm[7] = 0;
		cm[8] = cp;

		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				tm[r*3+k] = rmul30(bm[r*3], cm[k]) + rmul30(bm[r*3+1], cm[3+k])
					+ rmul30(bm[r*3+2], cm[6+k]);

		// frame counter wraps to one
		frame_num = frame_num + 14'd1;
		if (frame_num > 14'(WRAP_AT))
			frame_num = 14'd1;

		w[0] = MARKER;
		w[1] = longint'(frame_num) * ONE_Q32;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				w[2 + r*4 + k] = tm[k*3 + r] * 4;
		w[5] = ((lon * lc + (64'sd1 <<< 25)) >>> 26) * R_EARTH;
		w[9] = lat * R_EARTH * 16;
		w[13] = -((alt * FT_M + 64'sd128) >>> 8);
		w[14] = 60 * ONE_Q32;
		s1 = 0;
		s2 = 0;
		for (int i = 1; i <= 14; i++) begin
			s1 = sat_add64(s1, w[i]);
			s2 = (i % 2 == 1) ? sat_add64(s2, w[i]) : sat_add64(s2, -w[i]);
		end
		w[15] = s1;
		w[16] = s2;
		for (int i = 0; i < REC_LEN; i++) begin
			p.word_index = 5'(i);
			p.word_value = w[i];
			p.last_word = (i == REC_LEN - 1);
			pose_words_q.push_back(p);
		end
	endtask

	// send one attitude sample, with an optional idle burst first
	task automatic send_sample(input att_t s);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			@(negedge clk);
			att_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		att <= s;
		att_valid <= 1'b1;
		do @(posedge clk); while (!att_ready);
		predict_pose_record(s);
		samples_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		att_valid <= 1'b0;
	endtask

	// wait until every expected word has arrived
	task automatic drain();
		drop_valid();
		while (pose_words_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic att_t rand_sample(bit full);
		att_t s;
		s = {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		if (!full) begin
			// mostly plausible attitudes within +-pi
			s.cam_pitch    = $signed($urandom_range(0, 1686629712)) - 843314856;
			s.cam_heading  = $signed($urandom_range(0, 1686629712)) - 843314856;
			s.body_pitch   = $signed($urandom_range(0, 843314856)) - 421657428;
			s.body_roll    = $signed($urandom_range(0, 1686629712)) - 843314856;
			s.body_heading = $signed($urandom_range(0, 1686629712)) - 843314856;
			s.latitude     = $signed($urandom_range(0, 843314856)) - 421657428;
			s.longitude    = $signed($urandom_range(0, 1686629712)) - 843314856;
			s.altitude_ft  = $signed($urandom_range(0, 32'd40000 << 8));
		end
		return s;
	endfunction

	function automatic att_t all_fields(logic [31:0] v);
		return {8{v}};
	endfunction

	// extremes, angle reduction boundaries and bit patterns
	task automatic test_directed();
		att_t s;
		send_sample(all_fields(32'h0000_0000));
		send_sample(all_fields(32'h7FFF_FFFF));
		send_sample(all_fields(32'h8000_0000));
		send_sample(all_fields(32'hFFFF_FFFF));
		send_sample(all_fields(32'h0000_0001));
		send_sample(all_fields(32'h5555_5555));
		send_sample(all_fields(32'hAAAA_AAAA));
		// around +-pi and +-pi/2
		send_sample(all_fields(32'd843314856));
		send_sample(all_fields(32'd843314857));
		send_sample(all_fields(-32'sd843314856));
		send_sample(all_fields(-32'sd843314857));
		send_sample(all_fields(32'd421657428));
		send_sample(all_fields(32'd421657429));
		send_sample(all_fields(-32'sd421657428));
		send_sample(all_fields(-32'sd421657429));
		// position extremes with level attitude
		s = all_fields(32'h0);
		s.latitude = 32'h7FFF_FFFF;
		s.longitude = 32'h8000_0000;
		s.altitude_ft = 32'h8000_0000;
		send_sample(s);
		s.latitude = 32'h8000_0000;
		s.longitude = 32'h7FFF_FFFF;
		s.altitude_ft = 32'h7FFF_FFFF;
		send_sample(s);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_sample(rand_sample($urandom_range(0, 3) == 0));
	endtask

	// receiver holds off while samples keep coming
	task automatic test_backpressure();
		idle_on = 1'b0;
		@(negedge clk);
		hold_off_cycles = 900;
		for (int i = 0; i < 4; i++)
			send_sample(rand_sample(1'b0));
		drain();
		idle_on = 1'b1;
	endtask

	// receiver side: random stalls and the long hold-off
	initial begin
		int burst;
		pose_ready = 1'b0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				pose_ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				pose_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 14);
				pose_ready <= 1'b0;
			end else begin
				pose_ready <= 1'b1;
			end
		end
	end

	// compare each pose word with the oldest expectation
	always @(posedge clk) begin
		pose_t want;
		if (arst_n && pose_valid && pose_ready) begin
			words_checked++;
			if (pose_words_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected pose word: idx %0d value %h",
						pose.word_index, pose.word_value);
			end else begin
				want = pose_words_q.pop_front();
				if (pose.word_index !== want.word_index ||
					pose.word_value !== want.word_value ||
					pose.last_word !== want.last_word) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("pose mismatch: exp idx %0d val %h last %b, got idx %0d val %h last %b",
							want.word_index, want.word_value, want.last_word,
							pose.word_index, pose.word_value, pose.last_word);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((att_valid && att_ready) || (pose_valid && pose_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arctan_q30 = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
			64'h00000001};
		clk = 1'b0;
		arst_n = 1'b0;
		att_valid = 1'b0;
		att = '0;
		frame_num = '0;
		mismatch_cnt = 0;
		samples_sent = 0;
		words_checked = 0;
		quiet_cycles = 0;
		hold_off_cycles = 0;
		idle_on = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(150);
		test_backpressure();
		test_random(150);
		drain();
		idle_on = 1'b0;
		test_random(100);
		drain();

		$display("covered %0d attitude samples, %0d pose words checked, %0d mismatches",
			samples_sent, words_checked, mismatch_cnt);
		$display("included angle wrap edges, field extremes, long output stall and drains");
		if (mismatch_cnt == 0 && pose_words_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
